// File: hw/rtl/fstk_pkg.sv
// shared types and constants for the forth source tokenizer
package fstk_pkg;

  localparam int DEF_MAX_TEXT_BYTES   = 65536;
  localparam int DEF_MAX_NUMBER_CHARS = 128;

  // result queue depth, room for two pushes per word plus drain slack
  localparam int OQ_DEPTH = 4;

  // token kinds
  localparam logic [2:0] KIND_INT        = 3'd0;
  localparam logic [2:0] KIND_STR        = 3'd1;
  localparam logic [2:0] KIND_FLASH      = 3'd2;
  localparam logic [2:0] KIND_SYM        = 3'd3;
  localparam logic [2:0] KIND_OPEN_STR   = 3'd4;
  localparam logic [2:0] KIND_OPEN_FLASH = 3'd5;
  localparam logic [2:0] KIND_END        = 3'd6;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] int_value;
    logic [15:0]        start;
    logic [15:0]        length;
    logic               last;
  } tok_t;

  // up to two results from one word; second only with the first
  typedef struct packed {
    logic vld0;
    logic vld1;
    tok_t r0;
    tok_t r1;
  } tok_pair_t;

endpackage

// File: hw/rtl/fstk_lex.sv
// scanner state and per-word token decision
module fstk_lex #(
  parameter int MAX_TEXT_BYTES   = fstk_pkg::DEF_MAX_TEXT_BYTES,
  parameter int MAX_NUMBER_CHARS = fstk_pkg::DEF_MAX_NUMBER_CHARS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic [7:0]          text_byte,
  input  logic                end_of_text,
  output fstk_pkg::tok_pair_t res
);
  import fstk_pkg::*;

  localparam int POS_W = $clog2(MAX_TEXT_BYTES + 1);

  // scan modes; the pending ones stand for held-back lookahead bytes
  localparam logic [3:0] M_IDLE  = 4'd0;
  localparam logic [3:0] M_INT   = 4'd1;
  localparam logic [3:0] M_SYM   = 4'd2;
  localparam logic [3:0] M_STR   = 4'd3;
  localparam logic [3:0] M_FLASH = 4'd4;
  localparam logic [3:0] M_FLSP  = 4'd5;  // flash text, space held
  localparam logic [3:0] M_PMIN  = 4'd6;  // '-' held
  localparam logic [3:0] M_PS    = 4'd7;  // 's' held
  localparam logic [3:0] M_PDOT  = 4'd8;  // '.' held
  localparam logic [3:0] M_PSQ   = 4'd9;  // 's"' held
  localparam logic [3:0] M_PDP   = 4'd10; // '.(' held

  logic [3:0]       mode_r, mode_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic             neg_r, neg_nxt;
  logic [15:0]      start_r, start_nxt;
  logic [15:0]      len_r, len_nxt;

  logic [15:0] pos16, pm1, pm2, len_p1, len_p2;
  logic [35:0] prod;
  logic [31:0] acc_step, int_val;
  logic        full, is_dig, is_spc, is_sym, num_ok;
  logic        tok_vld, restart;
  tok_t        tok, end_tok;

  function automatic tok_t mk_tok(input logic [2:0] kind, input logic [31:0] val,
                                  input logic [15:0] start, input logic [15:0] length);
    tok_t t;
    t.kind      = kind;
    t.int_value = val;
    t.start     = start;
    t.length    = length;
    t.last      = 1'b1;
    return t;
  endfunction

  assign pos16  = 16'(pos_r);
  assign pm1    = pos16 - 16'd1;
  assign pm2    = pos16 - 16'd2;
  assign len_p1 = (len_r == 16'hffff) ? 16'hffff : len_r + 16'd1;
  assign len_p2 = (len_r >= 16'hfffe) ? 16'hffff : len_r + 16'd2;
  assign full   = pos_r >= POS_W'(MAX_TEXT_BYTES);
  assign num_ok = len_r < 16'(MAX_NUMBER_CHARS);

  assign is_dig = text_byte inside {[8'h30:8'h39]};
  assign is_spc = text_byte inside {8'h20, [8'h09:8'h0d]};
  assign is_sym = text_byte inside {[8'h61:8'h7a], [8'h41:8'h5a],
                                    8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h25, 8'h2e};

  // acc * 10 + digit, clamped at 2^31
  assign prod     = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {32'd0, text_byte[3:0]};
  assign acc_step = (prod > 36'h080000000) ? 32'h80000000 : prod[31:0];
  assign int_val  = neg_r ? (32'd0 - acc_r)
                          : ((acc_r > 32'h7fffffff) ? 32'h7fffffff : acc_r);

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    tok_vld   = 1'b0;
    tok       = mk_tok(KIND_INT, 32'd0, 16'd0, 16'd0);
    end_tok   = mk_tok(KIND_END, 32'd0, pos16, 16'd0);
    restart   = 1'b0;
    res       = '0;

    if (go && end_of_text) begin
      tok_vld = 1'b1;
      case (mode_r)
        M_INT: begin
          tok_vld = num_ok;
          tok     = mk_tok(KIND_INT, int_val, start_r, len_r);
        end
        M_SYM:   tok = mk_tok(KIND_SYM, 32'd0, start_r, len_r);
        M_STR:   tok = mk_tok(KIND_OPEN_STR, 32'd0, start_r, len_r);
        M_FLASH: tok = mk_tok(KIND_OPEN_FLASH, 32'd0, start_r, len_r);
        M_FLSP:  tok = mk_tok(KIND_OPEN_FLASH, 32'd0, start_r, len_p1);
        M_PMIN, M_PS, M_PDOT: tok = mk_tok(KIND_SYM, 32'd0, pm1, 16'd1);
        M_PSQ, M_PDP:         tok = mk_tok(KIND_SYM, 32'd0, pm2, 16'd1);
        default: tok_vld = 1'b0;
      endcase
      mode_nxt  = M_IDLE;
      pos_nxt   = '0;
      acc_nxt   = '0;
      neg_nxt   = 1'b0;
      start_nxt = '0;
      len_nxt   = '0;
      res.vld0  = 1'b1;
      if (tok_vld) begin
        res.r0      = tok;
        res.r0.last = 1'b0;
        res.vld1    = 1'b1;
        res.r1      = end_tok;
      end else begin
        res.r0 = end_tok;
      end
    end else if (go && !full) begin
      pos_nxt = pos_r + POS_W'(1);
      case (mode_r)
        M_IDLE: restart = 1'b1;
        M_INT: begin
          if (is_dig) begin
            acc_nxt = acc_step;
            len_nxt = len_p1;
          end else begin
            tok_vld = num_ok;
            tok     = mk_tok(KIND_INT, int_val, start_r, len_r);
            restart = 1'b1;
          end
        end
        M_SYM: begin
          if (is_sym) begin
            len_nxt = len_p1;
          end else begin
            tok_vld = 1'b1;
            tok     = mk_tok(KIND_SYM, 32'd0, start_r, len_r);
            restart = 1'b1;
          end
        end
        M_STR: begin
          if (text_byte == 8'h22) begin
            tok_vld  = 1'b1;
            tok      = mk_tok(KIND_STR, 32'd0, start_r, len_r);
            mode_nxt = M_IDLE;
          end else begin
            len_nxt = len_p1;
          end
        end
        M_FLASH: begin
          if (text_byte == 8'h20) begin
            mode_nxt = M_FLSP;
          end else begin
            len_nxt = len_p1;
          end
        end
        M_FLSP: begin
          if (text_byte == 8'h29) begin
            tok_vld  = 1'b1;
            tok      = mk_tok(KIND_FLASH, 32'd0, start_r, len_r);
            mode_nxt = M_IDLE;
          end else if (text_byte == 8'h20) begin
            len_nxt = len_p1;
          end else begin
            len_nxt  = len_p2;
            mode_nxt = M_FLASH;
          end
        end
        M_PMIN, M_PS, M_PDOT: begin
          if (mode_r == M_PMIN && is_dig) begin
            mode_nxt  = M_INT;
            start_nxt = pm1;
            neg_nxt   = 1'b1;
            acc_nxt   = {28'd0, text_byte[3:0]};
            len_nxt   = 16'd2;
          end else if (mode_r == M_PS && text_byte == 8'h22) begin
            mode_nxt = M_PSQ;
          end else if (mode_r == M_PDOT && text_byte == 8'h28) begin
            mode_nxt = M_PDP;
          end else if (is_sym) begin
            mode_nxt  = M_SYM;
            start_nxt = pm1;
            len_nxt   = 16'd2;
          end else begin
            tok_vld = 1'b1;
            tok     = mk_tok(KIND_SYM, 32'd0, pm1, 16'd1);
            restart = 1'b1;
          end
        end
        M_PSQ, M_PDP: begin
          if (text_byte == 8'h20) begin
            mode_nxt  = (mode_r == M_PSQ) ? M_STR : M_FLASH;
            start_nxt = pos16 + 16'd1;
            len_nxt   = 16'd0;
          end else begin
            // lone 's' or '.' becomes a symbol, the '"' or '(' is skipped
            tok_vld = 1'b1;
            tok     = mk_tok(KIND_SYM, 32'd0, pm2, 16'd1);
            restart = 1'b1;
          end
        end
        default: mode_nxt = M_IDLE;
      endcase

      // the new byte seen from idle
      if (restart) begin
        if (is_dig) begin
          mode_nxt  = M_INT;
          start_nxt = pos16;
          neg_nxt   = 1'b0;
          acc_nxt   = {28'd0, text_byte[3:0]};
          len_nxt   = 16'd1;
        end else if (text_byte == 8'h2d) begin
          mode_nxt = M_PMIN;
        end else if (text_byte == 8'h73) begin
          mode_nxt = M_PS;
        end else if (text_byte == 8'h2e) begin
          mode_nxt = M_PDOT;
        end else if (is_sym && !is_spc) begin
          mode_nxt  = M_SYM;
          start_nxt = pos16;
          len_nxt   = 16'd1;
        end else begin
          mode_nxt = M_IDLE;
        end
      end

      res.vld0 = tok_vld;
      res.r0   = tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pos_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    neg_r   <= neg_nxt;
    start_r <= start_nxt;
    len_r   <= len_nxt;
  end

  a_second_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld1 |-> (res.vld0 && go && end_of_text))
    else $error("second result outside end of text");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (go && end_of_text) |=> (mode_r == M_IDLE && pos_r == '0))
    else $error("scanner not cleared after end of text");

  a_int_has_value_only: assert property (@(posedge clk) disable iff (!rst_n)
    (res.vld0 && res.r0.kind != KIND_INT) |-> (res.r0.int_value == 32'sd0))
    else $error("non-integer token carries a value");

endmodule

// File: hw/rtl/fstk_outq.sv
// small result queue, up to two pushes and one pop per cycle, the pop held by out_stall
module fstk_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  fstk_pkg::tok_pair_t push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output fstk_pkg::tok_t      head
);
  import fstk_pkg::*;

  localparam int AW    = $clog2(OQ_DEPTH);
  localparam int CNT_W = AW + 1;

  tok_t             q_r [OQ_DEPTH];
  logic [AW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt, wr_p1;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       n_push;
  logic             pop;

  assign n_push    = {1'b0, push.vld0} + {1'b0, push.vld1};
  assign out_valid = count_r != '0;
  assign pop       = out_valid && !out_stall;
  assign room      = count_r <= CNT_W'(OQ_DEPTH - 2);
  assign head      = q_r[rd_r];
  assign wr_p1     = wr_r + AW'(1);

  always_comb begin
    wr_nxt    = wr_r + AW'(n_push);
    rd_nxt    = pop ? rd_r + AW'(1) : rd_r;
    count_nxt = count_r + CNT_W'(n_push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld0) begin
      q_r[wr_r] <= push.r0;
    end
    if (push.vld1) begin
      q_r[wr_p1] <= push.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ((CNT_W + 1)'(count_r) + (CNT_W + 1)'(n_push)) <= (CNT_W + 1)'(OQ_DEPTH))
    else $error("result queue overflow");

  a_pop_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && n_push == 2'd0) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("queue count lost a pop");

endmodule

// File: hw/rtl/forth_source_tokenizer_unit.sv
// forth source tokenizer top level: input register, scanner, result queue
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+-------------------------------------
//  in_     | input     | in_valid / in_stall   | text_byte, end_of_text
//  out_    | output    | out_valid / out_stall | token_kind, int_value, token_start,
//          |           |                       | token_length, last_of_run
//
//  one input word per cycle while the result queue has room: the scanner settles each word in a single pass
//  a result passes the input register and the result queue before it shows on out_; an
//  end-of-text word can push two results (pending token, then end marker)
//  in_stall rises only while the 4-entry result queue has fewer than two free slots:
//  under a long out_stall, once three results wait the next word holds in the input register
//  synchronous active-low reset; no clearing pass, scanner is idle right after reset
module forth_source_tokenizer_unit #(
  parameter int MAX_TEXT_BYTES   = fstk_pkg::DEF_MAX_TEXT_BYTES,
  parameter int MAX_NUMBER_CHARS = fstk_pkg::DEF_MAX_NUMBER_CHARS
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_token_kind,
  output logic signed [31:0] out_int_value,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic        out_last_of_run
);
  import fstk_pkg::*;

  // input register
  logic       s1_vld_r, s1_vld_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;

  logic       accept, advance, room;
  tok_pair_t  lex_res;
  tok_t       head;

  // the held word is handed to the scanner only when the queue can take
  // its worst case of two results
  assign advance  = s1_vld_r && room;
  assign in_stall = s1_vld_r && !room;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (advance) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  // payload only loads on accept, so a stalled word stays put
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_text_byte;
      s1_end_r  <= in_end_of_text;
    end
  end

  // scanner: mode, held lookahead, value and position, all updated per word
  fstk_lex #(
    .MAX_TEXT_BYTES   (MAX_TEXT_BYTES),
    .MAX_NUMBER_CHARS (MAX_NUMBER_CHARS)
  ) u_lex (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (advance),
    .text_byte   (s1_byte_r),
    .end_of_text (s1_end_r),
    .res         (lex_res)
  );

  // results wait here for the consumer
  fstk_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (lex_res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_token_kind   = head.kind;
  assign out_int_value    = head.int_value;
  assign out_token_start  = head.start;
  assign out_token_length = head.length;
  assign out_last_of_run  = head.last;

endmodule

// File: sim/tb.sv
// testbench for the forth source tokenizer: byte-stream stimulus, token prediction and checks
module tb;
  import fstk_pkg::*;

  localparam int MAX_TEXT_BYTES   = DEF_MAX_TEXT_BYTES;
  localparam int MAX_NUMBER_CHARS = DEF_MAX_NUMBER_CHARS;
  localparam int CYCLE_LIMIT      = 1000000;
  localparam int HOLD_CYCLES      = 150;
  localparam int TAIL_CYCLES      = 20;

  // peek results that are not bytes
  localparam int AT_END    = -1;
  localparam int NEED_MORE = -2;

  // characters the scanner reacts to
  localparam int CH_SPACE  = 8'h20;
  localparam int CH_QUOTE  = 8'h22;
  localparam int CH_LPAREN = 8'h28;
  localparam int CH_RPAREN = 8'h29;
  localparam int CH_MINUS  = 8'h2D;
  localparam int CH_DOT    = 8'h2E;
  localparam int CH_ZERO   = 8'h30;
  localparam int CH_S      = 8'h73;

  typedef enum logic [2:0] {SCAN_IDLE, SCAN_INT, SCAN_SYM, SCAN_STR, SCAN_FLASH} scan_mode_t;

  // tracks the lexer state word by word and holds the tokens still to come out
  class token_ledger;
    tok_t       expected_tokens[$];
    scan_mode_t mode;
    logic [7:0] look [3];
    int         look_n;
    logic [31:0] pos, acc, tok_start, tok_len;
    bit         neg;
    int         made;
    int         mismatches = 0;
    int         words_seen = 0;
    int         texts_closed = 0;
    int         tokens_checked = 0;
    int         tokens_predicted = 0;
    int         kind_hits [7] = '{0, 0, 0, 0, 0, 0, 0};

    function new();
      restart();
    endfunction

    function void restart();
      mode = SCAN_IDLE;
      look = '{8'h00, 8'h00, 8'h00};
      look_n = 0;
      pos = 0;
      acc = 0;
      neg = 0;
      tok_start = 0;
      tok_len = 0;
    endfunction

    function bit is_space(int c);
      return c == CH_SPACE || (c >= 9 && c <= 13);
    endfunction

    function bit is_digit(int c);
      return c >= CH_ZERO && c <= CH_ZERO + 9;
    endfunction

    function bit is_sym(int c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "+" || c == "-" ||
             c == "*" || c == "/" || c == "%" || c == ".";
    endfunction

    function int peek(int i, bit at_end);
      if (i < look_n) return look[i];
      return at_end ? AT_END : NEED_MORE;
    endfunction

    function void consume(int k);
      if (k > look_n) k = look_n;
      for (int i = 0; i + k < 3; i++) look[i] = look[i + k];
      look_n -= k;
    endfunction

    function logic [31:0] head();
      return pos - look_n;
    endfunction

    function void grow();
      if (tok_len < 32'hFFFF) tok_len++;
    endfunction

    function void open_token(scan_mode_t m, logic [31:0] s);
      mode = m;
      tok_start = s;
      tok_len = 0;
      acc = 0;
      neg = 0;
    endfunction

    function void emit(logic [2:0] kind, logic [31:0] val, logic [31:0] s, logic [31:0] len);
      tok_t t;
      if (made >= 3) return;
      t.kind = kind;
      t.int_value = $signed(val);
      t.start = s[15:0];
      t.length = (len > 32'hFFFF) ? 16'hFFFF : len[15:0];
      t.last = 1'b0;
      expected_tokens.push_back(t);
      made++;
      tokens_predicted++;
    endfunction

    // idle between tokens: returns 1 while the next token kind is still undecided
    function bit decide_idle(bit at_end);
      int c0, c1, c2;
      c0 = peek(0, at_end);
      if (is_space(c0)) begin
        consume(1);
        return 0;
      end
      if (is_digit(c0)) begin
        open_token(SCAN_INT, head());
        return 0;
      end
      if (c0 == CH_MINUS) begin
        c1 = peek(1, at_end);
        if (c1 == NEED_MORE) return 1;
        if (is_digit(c1)) begin
          open_token(SCAN_INT, head());
          neg = 1;
          grow();
          consume(1);
          return 0;
        end
      end
      if (c0 == CH_S || c0 == CH_DOT) begin
        c1 = peek(1, at_end);
        if (c1 == NEED_MORE) return 1;
        if (c1 == ((c0 == CH_S) ? CH_QUOTE : CH_LPAREN)) begin
          c2 = peek(2, at_end);
          if (c2 == NEED_MORE) return 1;
          if (c2 == CH_SPACE) begin
            if (c0 == CH_S) open_token(SCAN_STR, head() + 3);
            else open_token(SCAN_FLASH, head() + 3);
            consume(3);
            return 0;
          end
        end
      end
      if (is_sym(c0)) begin
        open_token(SCAN_SYM, head());
        return 0;
      end
      consume(1);
      return 0;
    endfunction

    function void lex_forward(bit at_end);
      int c0, c1;
      bit closing;
      logic [63:0] wide;
      logic [31:0] v;
      forever begin
        c0 = peek(0, at_end);
        if (c0 == NEED_MORE) return;
        case (mode)
          SCAN_IDLE: begin
            if (c0 == AT_END) return;
            if (decide_idle(at_end)) return;
          end
          SCAN_INT: begin
            if (is_digit(c0)) begin
              wide = 64'(acc) * 10 + 64'(c0 - CH_ZERO);
              acc = (wide > 64'h8000_0000) ? 32'h8000_0000 : wide[31:0];
              grow();
              consume(1);
            end else begin
              if (tok_len < MAX_NUMBER_CHARS) begin
                if (neg) v = 32'd0 - acc;
                else v = (acc > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc;
                emit(KIND_INT, v, tok_start, tok_len);
              end
              mode = SCAN_IDLE;
            end
          end
          SCAN_SYM: begin
            if (c0 != AT_END && is_sym(c0)) begin
              grow();
              consume(1);
            end else begin
              emit(KIND_SYM, 0, tok_start, tok_len);
              mode = SCAN_IDLE;
            end
          end
          SCAN_STR: begin
            if (c0 == AT_END) begin
              emit(KIND_OPEN_STR, 0, tok_start, tok_len);
              mode = SCAN_IDLE;
            end else if (c0 == CH_QUOTE) begin
              consume(1);
              emit(KIND_STR, 0, tok_start, tok_len);
              mode = SCAN_IDLE;
            end else begin
              grow();
              consume(1);
            end
          end
          default: begin
            if (c0 == AT_END) begin
              emit(KIND_OPEN_FLASH, 0, tok_start, tok_len);
              mode = SCAN_IDLE;
            end else begin
              closing = 0;
              if (c0 == CH_SPACE) begin
                c1 = peek(1, at_end);
                if (c1 == NEED_MORE) return;
                closing = (c1 == CH_RPAREN);
              end
              if (closing) begin
                consume(2);
                emit(KIND_FLASH, 0, tok_start, tok_len);
                mode = SCAN_IDLE;
              end else begin
                grow();
                consume(1);
              end
            end
          end
        endcase
      end
    endfunction

    // one accepted input word; appends the tokens it releases
    function void take_word(logic [7:0] b, logic eot);
      tok_t t;
      words_seen++;
      made = 0;
      if (eot) begin
        texts_closed++;
        lex_forward(1'b1);
        emit(KIND_END, 0, pos, 0);
        restart();
      end else begin
        if (pos >= MAX_TEXT_BYTES || look_n >= 3) return;
        look[look_n] = b;
        look_n++;
        pos++;
        lex_forward(1'b0);
      end
      if (made > 0) begin
        t = expected_tokens.pop_back();
        t.last = 1'b1;
        expected_tokens.push_back(t);
      end
    endfunction

    task report_mismatch(string what, longint got, longint want);
      mismatches++;
      if (mismatches <= 40)
        $display("mismatch on %s at token %0d: got %0d, expected %0d",
                 what, tokens_checked, got, want);
    endtask

    task match_token(tok_t got);
      tok_t want;
      if (expected_tokens.size() == 0) begin
        report_mismatch("unexpected token kind", got.kind, -1);
        return;
      end
      want = expected_tokens.pop_front();
      kind_hits[want.kind]++;
      if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
      if (got.int_value != want.int_value)
        report_mismatch("int value", got.int_value, want.int_value);
      if (got.start != want.start) report_mismatch("start", got.start, want.start);
      if (got.length != want.length) report_mismatch("length", got.length, want.length);
      if (got.last != want.last) report_mismatch("last flag", got.last, want.last);
      tokens_checked++;
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_text_byte = 8'h00;
  logic               in_end_of_text = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_token_kind;
  logic signed [31:0] out_int_value;
  logic [15:0]        out_token_start;
  logic [15:0]        out_token_length;
  logic               out_last_of_run;

  token_ledger ledger = new();

  // source text staged for the next feed
  logic [7:0] pending_text[$];
  string      sym_chars = "azAZqm+-*/%.";
  logic [7:0] ws_set [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  // shared knobs: calm_* switches off idling on that side, hold_request asks for a long stall
  bit calm_in = 1'b0;
  bit calm_out = 1'b0;
  bit hold_request = 1'b0;
  int cycle_count = 0;

  forth_source_tokenizer_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_int_value    (out_int_value),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

  always #2 clk = ~clk;

  // watchdog, far above the slowest legal run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tokens outstanding",
               cycle_count, ledger.expected_tokens.size());
      $display("tb failed");
      $finish;
    end
  end

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void put(string s);
    for (int i = 0; i < s.len(); i++) pending_text.push_back(s[i]);
  endfunction

  // body of a string or flash message, sometimes with high bytes
  function automatic void add_content();
    repeat ($urandom_range(0, 8))
      pending_text.push_back(8'(($urandom_range(0, 9) == 0) ? $urandom_range(128, 255)
                                                             : $urandom_range(32, 126)));
  endfunction

  // one random token, mostly well formed, sometimes broken or noise
  function automatic void add_fragment();
    int n;
    case ($urandom_range(0, 9))
      0, 1: begin
        if ($urandom_range(0, 2) == 0) put("-");
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 5);
        repeat (n) pending_text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      end
      2: begin
        put("s\" ");
        add_content();
        if ($urandom_range(0, 7) != 0) put("\"");
      end
      3: begin
        put(".( ");
        add_content();
        if ($urandom_range(0, 7) != 0) put(" )");
      end
      4, 5, 6: begin
        repeat ($urandom_range(1, 6))
          pending_text.push_back(sym_chars[$urandom_range(0, sym_chars.len() - 1)]);
      end
      7: begin
        // prefixes of a string, flash or negative number, and a flash whose ')' lacks the space before it
        case ($urandom_range(0, 5))
          0: put("s\"");
          1: put(".(");
          2: put("s\"x");
          3: put(".(x");
          4: put("-");
          default: put(".( x)");
        endcase
      end
      8: begin
        repeat ($urandom_range(1, 2)) pending_text.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        // symbol running straight into a number
        pending_text.push_back(sym_chars[$urandom_range(0, sym_chars.len() - 1)]);
        repeat ($urandom_range(1, 3)) pending_text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      end
    endcase
  endfunction

  // offer one word and hold it until the block takes it
  task automatic offer_word(logic [7:0] b, logic eot);
    int gap;
    gap = calm_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.take_word(b, eot);
  endtask

  task automatic feed_text();
    foreach (pending_text[i]) offer_word(pending_text[i], 1'b0);
    pending_text.delete();
  endtask

  // end of text; the byte that rides along is ignored, so it is random
  task automatic close_text();
    offer_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // sender stops until every predicted token has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (ledger.expected_tokens.size() != 0);
  endtask

  // receiver side: random stall stretches, plus one long hold on request
  initial begin
    int n;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = calm_out ? 0 : pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  end

  // result monitor, samples the values present at the edge
  always @(posedge clk) begin : watch_tokens
    tok_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind = out_token_kind;
      got.int_value = out_int_value;
      got.start = out_token_start;
      got.length = out_token_length;
      got.last = out_last_of_run;
      ledger.match_token(got);
    end
  end

  initial begin
    int base_words;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // saturation on both sides, minus right after a number
    put("-2147483649 2147483648 12-3");
    feed_text();
    close_text();

    // closed string, flash and symbol, lone minus, near-miss openers, zero and all-ones bytes
    put("s\" hi\" .( a ) b+-Z -x - s\"q .(x");
    pending_text.push_back(8'h00);
    pending_text.push_back(8'hFF);
    feed_text();
    close_text();

    // open string cut off by end of text, flash with trailing whitespace at the end
    put("s\" o");
    feed_text();
    close_text();
    put(".( t ");
    feed_text();
    close_text();

    // opener and minus still in lookahead at the end, then an empty text
    put("s\"");
    feed_text();
    close_text();
    put("-");
    feed_text();
    close_text();
    close_text();
    wait_drained();

    // back-pressure: receiver holds off while a dense burst fills the result queue
    hold_request = 1'b1;
    while (hold_request) @(posedge clk);
    calm_in = 1'b1;
    repeat (6) put("7 ");
    feed_text();
    close_text();
    calm_in = 1'b0;
    wait_drained();

    // random texts built from token fragments and separators
    base_words = ledger.words_seen;
    while (ledger.words_seen - base_words < 30) begin
      calm_in = ($urandom_range(0, 4) == 0);
      calm_out = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 5)) begin
        add_fragment();
        if ($urandom_range(0, 6) != 0) pending_text.push_back(ws_set[$urandom_range(0, 5)]);
      end
      feed_text();
      close_text();
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    calm_in = 1'b0;
    calm_out = 1'b0;

    // all words in; let the last tokens out, then watch for strays
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d words in %0d texts, %0d tokens checked, %0d mismatches",
             ledger.words_seen, ledger.texts_closed, ledger.tokens_checked, ledger.mismatches);
    $display("tokens by kind: int %0d str %0d flash %0d sym %0d open-str %0d open-flash %0d end %0d",
             ledger.kind_hits[0], ledger.kind_hits[1], ledger.kind_hits[2], ledger.kind_hits[3],
             ledger.kind_hits[4], ledger.kind_hits[5], ledger.kind_hits[6]);
    if (ledger.mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
